// ----- sv/c32e_pkg.sv -----
// Shared types, sizes and CRC-32 matrix builders for the eight-byte CRC stream.
`default_nettype none
package c32e_pkg;

  localparam int BYTES_PER_ITEM = 8;
  localparam int DATA_BYTES     = 8;
  localparam int LANES          = (BYTES_PER_ITEM < DATA_BYTES) ? BYTES_PER_ITEM : DATA_BYTES;
  localparam int CNT_W          = $clog2(LANES + 1);
  localparam int IDX_W          = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int VB_W           = 4;
  localparam int SEED_W         = 32;
  localparam int IN_FIELDS_W    = 8 * DATA_BYTES + VB_W + SEED_W;
  localparam int IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = 32;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  typedef logic [31:0]           crc_t;
  typedef logic [31:0][31:0]     mat32_t;  // [input bit] -> output column
  typedef logic [7:0][31:0]      mat8_t;
  typedef logic [LANES-1:0][31:0] lane_vec_t;

  // Shift nbits zero bits through the reflected LFSR (elaboration only).
  function automatic crc_t crc_shift_bits(crc_t c, int nbits);
    crc_t r;
    r = c;
    for (int k = 0; k < nbits; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  // Linear map of the register advanced over n zero bytes.
  function automatic mat32_t adv_mat(int n);
    mat32_t m;
    for (int j = 0; j < 32; j++) begin
      m[j] = crc_shift_bits(crc_t'(1) << j, 8 * n);
    end
    return m;
  endfunction

  // Contribution of one byte that is followed by d more bytes.
  function automatic mat8_t lane_mat(int d);
    mat8_t m;
    for (int k = 0; k < 8; k++) begin
      m[k] = crc_shift_bits(crc_shift_bits(crc_t'(1) << k, 8), 8 * d);
    end
    return m;
  endfunction

  function automatic crc_t apply32(mat32_t m, crc_t x);
    crc_t r;
    r = '0;
    for (int j = 0; j < 32; j++) begin
      if (x[j]) r = r ^ m[j];
    end
    return r;
  endfunction

  function automatic crc_t apply8(mat8_t m, logic [7:0] b);
    crc_t r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r = r ^ m[k];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/c32e_lane.sv -----
// One byte lane: CRC contribution of its byte given the item's byte count.
`default_nettype none
module c32e_lane
  import c32e_pkg::*;
(
  input  wire logic [7:0]       lane_byte,
  input  wire logic [CNT_W-1:0] cnt,
  input  wire logic [IDX_W-1:0] lane_idx,
  output logic [31:0]           contrib
);

  crc_t              cand [LANES];
  logic [IDX_W-1:0]  tail_cnt;
  logic              active;

  for (genvar d = 0; d < LANES; d++) begin : g_tail
    localparam mat8_t M = lane_mat(d);
    assign cand[d] = apply8(M, lane_byte);
  end

  // bytes still to come after this one
  assign active   = CNT_W'(lane_idx) < cnt;
  assign tail_cnt = IDX_W'(cnt - CNT_W'(lane_idx) - CNT_W'(1));

  always_comb begin
    contrib = '0;
    if (active) contrib = cand[tail_cnt];
  end

endmodule
`default_nettype wire

// ----- sv/c32e_merge.sv -----
// Merge stage: advance the start value by the byte count and fold in all lanes.
`default_nettype none
module c32e_merge
  import c32e_pkg::*;
(
  input  wire logic [31:0]      start,
  input  wire logic [CNT_W-1:0] cnt,
  input  wire lane_vec_t        lanes,
  output logic [31:0]           crc_nxt
);

  crc_t adv [LANES+1];
  crc_t lane_xor;

  for (genvar n = 0; n <= LANES; n++) begin : g_adv
    localparam mat32_t M = adv_mat(n);
    assign adv[n] = apply32(M, start);
  end

  always_comb begin
    lane_xor = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_xor = lane_xor ^ lanes[i];
    end
  end

  assign crc_nxt = adv[cnt] ^ lane_xor;

endmodule
`default_nettype wire

// ----- sv/crc32_eight_byte_stream.sv -----
// Top level: reflected CRC-32 over up to eight bytes per request, one request per cycle unless a held result stalls.
//
//  channel | dir | handshake            | payload
//  in_     | in  | tvalid/tready/tlast  | tdata: data, valid_bytes, seed; tuser: first
//  out_    | out | tvalid/tready        | tdata: crc_value
//
// One request per cycle sustained while no held result stalls; path: lane stage reg, then merge into output reg.
// The rate is set by the running-CRC loop: register -> count-selected advance matrix -> XOR.
// Reset clears the stage valids and loads the running CRC with all ones.
// A held result stalls only a tlast request in the merge stage, and the input behind it;
// requests without tlast keep flowing past it.
`default_nettype none
module crc32_eight_byte_stream
  import c32e_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [63:0] data, [67:64] valid_bytes, [99:68] seed, rest zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] first
  input  wire logic                   in_tuser,
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [31:0] crc_value
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic [VB_W-1:0]  in_vb;
  logic [CNT_W-1:0] in_cnt;
  lane_vec_t        lane_res;

  lane_vec_t        s1_lane_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             s1_first_r;
  logic [31:0]      s1_seed_r;
  logic             s1_last_r;
  logic             s1_valid_r, s1_valid_nxt;

  crc_t             running_r, running_nxt;
  crc_t             start;
  crc_t             crc_nxt;
  logic             out_free;
  logic             s1_fire;
  logic             in_fire;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r;

  assign in_vb  = in_tdata[8*DATA_BYTES +: VB_W];
  assign in_cnt = (in_vb > VB_W'(LANES)) ? CNT_W'(LANES) : CNT_W'(in_vb);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    c32e_lane u_lane (
      .lane_byte (in_tdata[8*i +: 8]),
      .cnt       (in_cnt),
      .lane_idx  (IDX_W'(i)),
      .contrib   (lane_res[i])
    );
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign start = s1_first_r ? ~s1_seed_r : running_r;

  c32e_merge u_merge (
    .start   (start),
    .cnt     (s1_cnt_r),
    .lanes   (s1_lane_r),
    .crc_nxt (crc_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (s1_fire) s1_valid_nxt = 1'b0;

    running_nxt = running_r;
    if (s1_fire) running_nxt = s1_last_r ? CRC_ONES : crc_nxt;

    out_valid_nxt = out_valid_r && !out_tready;
    if (s1_fire && s1_last_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      running_r   <= CRC_ONES;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      running_r   <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_lane_r  <= lane_res;
      s1_cnt_r   <= in_cnt;
      s1_first_r <= in_tuser;
      s1_seed_r  <= in_tdata[8*DATA_BYTES+VB_W +: SEED_W];
      s1_last_r  <= in_tlast;
    end
    if (s1_fire && s1_last_r) out_data_r <= ~crc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty lane stage");

  a_reinit_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> running_r == CRC_ONES)
    else $error("running CRC not reinitialized after last");

  a_out_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_fire && s1_last_r))
    else $error("result appeared without a last request");

  a_cnt_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> s1_cnt_r <= CNT_W'(LANES))
    else $error("byte count exceeds lane count");
`endif

endmodule
`default_nettype wire
